// ----- rtl/pl_pkg.sv -----
package pl_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_POS = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    // per-cycle operation broadcast to the cell row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] pos0;      // zero-based target position
        logic [IDX_W-1:0] last_idx;  // index of the back entry
    } t_cell_ctl;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

// ----- rtl/positional_list_engine.sv -----
// positional_list_engine: bounded ordered list held in a row of shifting cells.
// Insert and delete each give one result beat; a new command is taken the cycle
// after, as long as the output register is free or draining. Dump gives one beat
// per stored entry (one beat when empty), one per cycle while the output is free,
// by rotating the occupied cells; no command is taken until its last beat.
// Reset (synchronous, active low) empties the list and clears the output valid.
module positional_list_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [pl_pkg::POS_W-1:0]    i_position,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_element,
    output logic                        o_element_valid,
    output logic                        o_last_of_run,
    output logic [4:0]                  o_entry_count
);

    localparam int CAP   = pl_pkg::CAPACITY;
    localparam int IDX_W = pl_pkg::IDX_W;
    localparam int CNT_W = pl_pkg::CNT_W;
    localparam int CMP_W = pl_pkg::CMP_W;
    localparam int DW    = pl_pkg::DATA_W;

    pl_pkg::t_state         r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_dump_idx, n_dump_idx;
    logic                   r_out_valid, n_out_valid;
    logic                   out_load;

    logic [1:0]             r_status, n_status;
    logic [DW-1:0]          r_element, n_element;
    logic                   r_elem_valid, n_elem_valid;
    logic                   r_last, n_last;

    pl_pkg::t_cell_ctl      cell_ctl;
    logic [DW-1:0]          cell_data [CAP];

    logic                   out_free;
    logic                   accept;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [IDX_W-1:0]       last_idx;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == pl_pkg::S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign pos_ext  = CMP_W'(i_position);
    assign cnt_ext  = CMP_W'(r_count);
    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    // command decode, dump sequencing and output register load
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dump_idx   = r_dump_idx;
        n_out_valid  = r_out_valid && !i_ready;
        out_load     = 1'b0;
        n_status     = pl_pkg::STS_OK;
        n_element    = '0;
        n_elem_valid = 1'b0;
        n_last       = 1'b1;
        cell_ctl.op       = pl_pkg::OP_HOLD;
        cell_ctl.pos0     = IDX_W'(pos_ext - CMP_W'(1));
        cell_ctl.last_idx = last_idx;

        unique case (r_state)
            pl_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        pl_pkg::CMD_INSERT: begin
                            out_load = 1'b1;
                            if (cnt_ext >= CMP_W'(CAP)) begin
                                n_status = pl_pkg::STS_FULL;
                            end else if (pos_ext < CMP_W'(1) ||
                                         pos_ext > cnt_ext + CMP_W'(1)) begin
                                n_status = pl_pkg::STS_BAD_POS;
                            end else begin
                                cell_ctl.op = pl_pkg::OP_INSERT;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        pl_pkg::CMD_DELETE: begin
                            out_load = 1'b1;
                            if (r_count == '0) begin
                                n_status = pl_pkg::STS_EMPTY;
                            end else if (pos_ext < CMP_W'(1) || pos_ext > cnt_ext) begin
                                n_status = pl_pkg::STS_BAD_POS;
                            end else begin
                                cell_ctl.op = pl_pkg::OP_DELETE;
                                n_count     = r_count - CNT_W'(1);
                            end
                        end
                        pl_pkg::CMD_DUMP: begin
                            if (r_count == '0) begin
                                out_load = 1'b1;
                                n_status = pl_pkg::STS_EMPTY;
                            end else begin
                                n_state    = pl_pkg::S_DUMP;
                                n_dump_idx = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pl_pkg::S_DUMP: begin
                // one entry per beat from the front, rotating it to the back
                if (out_free) begin
                    out_load     = 1'b1;
                    cell_ctl.op  = pl_pkg::OP_ROTATE;
                    n_element    = cell_data[0];
                    n_elem_valid = 1'b1;
                    n_last       = (r_dump_idx == last_idx);
                    n_dump_idx   = r_dump_idx + IDX_W'(1);
                    if (r_dump_idx == last_idx) begin
                        n_state = pl_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = pl_pkg::S_IDLE;
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pl_pkg::S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with the count after the operation
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status     <= n_status;
            r_element    <= n_element;
            r_elem_valid <= n_elem_valid;
            r_last       <= n_last;
        end
    end

    logic [4:0] r_out_count;
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= 5'(n_count);
        end
    end

    // row of cells, each fed by its neighbors and the front entry
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [DW-1:0] left_data;
        logic [DW-1:0] right_data;
        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid
            assign left_data = cell_data[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end
        pl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_idx   (IDX_W'(g)),
            .i_value (i_value),
            .i_left  (left_data),
            .i_right (right_data),
            .i_front (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_element       = r_element;
    assign o_element_valid = r_elem_valid;
    assign o_last_of_run   = r_last;
    assign o_entry_count   = r_out_count;

endmodule

// ----- rtl/pl_cell.sv -----
module pl_cell (
    input  logic                        i_clk,
    input  pl_pkg::t_cell_ctl           i_ctl,
    input  logic [pl_pkg::IDX_W-1:0]    i_idx,
    input  logic [pl_pkg::DATA_W-1:0]   i_value,
    input  logic [pl_pkg::DATA_W-1:0]   i_left,
    input  logic [pl_pkg::DATA_W-1:0]   i_right,
    input  logic [pl_pkg::DATA_W-1:0]   i_front,
    output logic [pl_pkg::DATA_W-1:0]   o_data
);

    logic [pl_pkg::DATA_W-1:0] r_data;
    logic [pl_pkg::DATA_W-1:0] n_data;

    // pick the next entry from own, neighbor, new value or the front (rotate)
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            pl_pkg::OP_INSERT: begin
                if (i_idx == i_ctl.pos0) begin
                    n_data = i_value;
                end else if (i_idx > i_ctl.pos0) begin
                    n_data = i_left;
                end
            end
            pl_pkg::OP_DELETE: begin
                if (i_idx >= i_ctl.pos0) begin
                    n_data = i_right;
                end
            end
            pl_pkg::OP_ROTATE: begin
                if (i_idx == i_ctl.last_idx) begin
                    n_data = i_front;
                end else if (i_idx < i_ctl.last_idx) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- sim/positional_list_engine_tb.sv -----
module positional_list_engine_tb;

    // command code that the block must ignore
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 21;
    localparam int         ERR_PRINT_MAX = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_cmd;
    logic [pl_pkg::POS_W-1:0]  i_position;
    logic signed [31:0]        i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic [1:0]                o_status;
    logic signed [31:0]        o_element;
    logic                      o_element_valid;
    logic                      o_last_of_run;
    logic [4:0]                o_entry_count;

    // one result beat as the list should produce it
    typedef struct {
        pl_pkg::t_status    status;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last_of_run;
        logic [4:0]         entry_count;
    } t_list_beat;

    t_list_beat         beats_due[$];
    logic signed [31:0] list_cells[pl_pkg::CAPACITY];
    int                 list_len;
    int                 err_count;
    int                 beats_checked;
    int                 cmds_sent;
    int                 dumps_sent;
    int                 ignored_sent;
    int                 hold_left;
    bit                 rx_steady;
    bit                 tx_steady;

    positional_list_engine u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last_of_run   (o_last_of_run),
        .o_entry_count   (o_entry_count)
    );

    // 10 unit clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= ERR_PRINT_MAX)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function automatic void push_beat(input pl_pkg::t_status s,
                                      input logic signed [31:0] elem,
                                      input logic ev, input logic last);
        t_list_beat b;
        b.status        = s;
        b.element       = elem;
        b.element_valid = ev;
        b.last_of_run   = last;
        b.entry_count   = 5'(list_len);
        beats_due.push_back(b);
    endfunction

    // list behavior: update the shadow list and queue the beats it should give
    function automatic void predict_command(input logic [1:0] cmd,
                                            input logic [pl_pkg::POS_W-1:0] pos,
                                            input logic signed [31:0] val);
        int p;
        int k;
        p = int'(pos);
        case (cmd)
            pl_pkg::CMD_INSERT: begin
                // full is checked ahead of the position
                if (list_len >= pl_pkg::CAPACITY) begin
                    push_beat(pl_pkg::STS_FULL, 0, 1'b0, 1'b1);
                end else if (p < 1 || p > list_len + 1) begin
                    push_beat(pl_pkg::STS_BAD_POS, 0, 1'b0, 1'b1);
                end else begin
                    for (k = list_len; k >= p; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[p-1] = val;
                    list_len++;
                    push_beat(pl_pkg::STS_OK, 0, 1'b0, 1'b1);
                end
            end
            pl_pkg::CMD_DELETE: begin
                // empty is checked ahead of the position
                if (list_len == 0) begin
                    push_beat(pl_pkg::STS_EMPTY, 0, 1'b0, 1'b1);
                end else if (p < 1 || p > list_len) begin
                    push_beat(pl_pkg::STS_BAD_POS, 0, 1'b0, 1'b1);
                end else begin
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                    push_beat(pl_pkg::STS_OK, 0, 1'b0, 1'b1);
                end
            end
            pl_pkg::CMD_DUMP: begin
                if (list_len == 0) begin
                    push_beat(pl_pkg::STS_EMPTY, 0, 1'b0, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++)
                        push_beat(pl_pkg::STS_OK, list_cells[k], 1'b1,
                                  (k == list_len - 1));
                end
            end
            default: ;
        endcase
    endfunction

    // offer one command beat, with occasional idle cycles ahead of it
    task automatic send_command(input logic [1:0] cmd, input int pos,
                                input logic signed [31:0] val);
        while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pl_pkg::POS_W'(pos);
        i_value    <= val;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_command(cmd, pl_pkg::POS_W'(pos), val);
        cmds_sent++;
        if (cmd == pl_pkg::CMD_DUMP)
            dumps_sent++;
        if (cmd == CMD_UNUSED)
            ignored_sent++;
    endtask

    // stop offering and wait until every pending beat has come back
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_beat();
        t_list_beat want;
        if (beats_due.size() == 0) begin
            report_mismatch($sformatf("beat with nothing pending: status %0d element %h",
                                      o_status, o_element));
        end else begin
            want = beats_due.pop_front();
            if (o_status !== want.status)
                report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                          beats_checked, o_status, want.status));
            if (o_element !== want.element)
                report_mismatch($sformatf("beat %0d element got %h want %h",
                                          beats_checked, o_element, want.element));
            if (o_element_valid !== want.element_valid)
                report_mismatch($sformatf("beat %0d element_valid got %b want %b",
                                          beats_checked, o_element_valid, want.element_valid));
            if (o_last_of_run !== want.last_of_run)
                report_mismatch($sformatf("beat %0d last_of_run got %b want %b",
                                          beats_checked, o_last_of_run, want.last_of_run));
            if (o_entry_count !== want.entry_count)
                report_mismatch($sformatf("beat %0d entry_count got %0d want %0d",
                                          beats_checked, o_entry_count, want.entry_count));
        end
        beats_checked++;
    endtask

    // result side: check accepted beats, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            check_beat();
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (rx_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // empty list: dump, deletes, bad inserts and the unused code
    task automatic test_empty_list();
        send_command(pl_pkg::CMD_DUMP, 1, 0);
        send_command(pl_pkg::CMD_DELETE, 1, 0);
        send_command(pl_pkg::CMD_DELETE, 0, 0);
        send_command(pl_pkg::CMD_INSERT, 0, 32'sh1234_5678);
        send_command(pl_pkg::CMD_INSERT, 2, 32'sh1234_5678);
        send_command(CMD_UNUSED, 31, -1);
        wait_drain();
    endtask

    // fill at front, back and middle, then hit the full and edge cases
    task automatic test_fill_and_full();
        int                 k;
        int                 p;
        logic signed [31:0] v;
        for (k = 0; k < pl_pkg::CAPACITY; k++) begin
            case (k)
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = -1;
                3:       v = 0;
                4:       v = 32'sh5555_5555;
                5:       v = 32'shAAAA_AAAA;
                default: v = $urandom;
            endcase
            if (k % 3 == 0)
                p = 1;
            else if (k % 3 == 1)
                p = list_len + 1;
            else
                p = list_len / 2 + 1;
            send_command(pl_pkg::CMD_INSERT, p, v);
        end
        send_command(pl_pkg::CMD_INSERT, 31, $urandom);
        send_command(pl_pkg::CMD_DUMP, 0, 0);
        send_command(pl_pkg::CMD_DELETE, 0, 0);
        send_command(pl_pkg::CMD_DELETE, 17, 0);
        send_command(pl_pkg::CMD_DELETE, 16, 0);
        send_command(pl_pkg::CMD_DELETE, 1, 0);
        send_command(pl_pkg::CMD_DELETE, 7, 0);
        send_command(pl_pkg::CMD_DUMP, 0, 0);
        wait_drain();
    endtask

    // result side held off while commands keep coming, so the input stalls
    task automatic test_output_stall();
        int k;
        hold_left = 80;
        tx_steady = 1'b1;
        for (k = 0; k < 10; k++) begin
            if (k % 4 == 3)
                send_command(pl_pkg::CMD_DUMP, 0, 0);
            else if (k % 2 == 0)
                send_command(pl_pkg::CMD_INSERT, 1, $urandom);
            else
                send_command(pl_pkg::CMD_DELETE, list_len, 0);
        end
        tx_steady = 1'b0;
        wait_drain();
    endtask

    // mostly legal traffic steered around the list size, some noise
    task automatic test_random_traffic(input int n);
        int         k;
        int         r;
        int         ins_pct;
        logic [1:0] c;
        for (k = 0; k < n; k++) begin
            tx_steady = (k >= 20 && k < 40);
            rx_steady = tx_steady;
            if (k == 48)
                wait_drain();
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_command(CMD_UNUSED, $urandom_range(0, 31), $urandom);
            end else if (r < 14) begin
                c = $urandom_range(0, 1) ? pl_pkg::CMD_DELETE : pl_pkg::CMD_INSERT;
                send_command(c, $urandom_range(0, 31), $urandom);
            end else if (r < 24) begin
                send_command(pl_pkg::CMD_DUMP, $urandom_range(0, 31), $urandom);
            end else begin
                ins_pct = (list_len < 4) ? 80 : (list_len > 12) ? 30 : 55;
                if (list_len == 0 || $urandom_range(0, 99) < ins_pct)
                    send_command(pl_pkg::CMD_INSERT, $urandom_range(1, list_len + 1),
                                 $urandom);
                else
                    send_command(pl_pkg::CMD_DELETE, $urandom_range(1, list_len), $urandom);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = pl_pkg::CMD_INSERT;
        i_position    = '0;
        i_value       = '0;
        i_ready       = 1'b0;
        list_len      = 0;
        err_count     = 0;
        beats_checked = 0;
        cmds_sent     = 0;
        dumps_sent    = 0;
        ignored_sent  = 0;
        hold_left     = 0;
        rx_steady     = 1'b0;
        tx_steady     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_full();
        test_output_stall();
        test_random_traffic(60);

        repeat (10) @(posedge i_clk);
        if (beats_due.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", beats_due.size()));

        $display("Ran %0d commands (%0d dumps, %0d with the unused code), checked %0d beats",
                 cmds_sent, dumps_sent, ignored_sent, beats_checked);
        $display("including a full list, an empty list, bad positions and output backpressure");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
